/* sv/satellite_table_with_aging_recycle_defines.svh */
// Assertion macros used by the satellite table datapath.
// Each macro expects clk and rst to be visible in the module that uses it.
`ifndef SATELLITE_TABLE_WITH_AGING_RECYCLE_DEFINES_SVH
`define SATELLITE_TABLE_WITH_AGING_RECYCLE_DEFINES_SVH

// The property must hold in the same cycle as the condition.
`define STAWR_ASSERT_IMPL(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

// The property must hold in the cycle after the condition.
`define STAWR_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);

`endif

/* sv/stawr_pkg.sv */
// Package for the satellite table: beat types, result kinds, register indexes,
// controller command and status structs and default parameter values.
// Depends on nothing.
package stawr_pkg;

  localparam int SLOTS_DEFAULT     = 16;
  localparam int TIME_BITS_DEFAULT = 32;

  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 32;

  localparam logic [CFG_INDEX_BITS-1:0] REG_RECYCLE = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_RECENT  = 2'd1;

  localparam logic [31:0] RECYCLE_RESET = 32'd10000;
  localparam logic [31:0] RECENT_RESET  = 32'd10000;

  localparam logic MODE_STORE = 1'b0;
  localparam logic MODE_LIST  = 1'b1;

  localparam logic [2:0] KIND_MATCH   = 3'd0;
  localparam logic [2:0] KIND_FREE    = 3'd1;
  localparam logic [2:0] KIND_RECYCLE = 3'd2;
  localparam logic [2:0] KIND_LIST    = 3'd3;
  localparam logic [2:0] KIND_EMPTY   = 3'd4;

  typedef struct packed {
    logic        mode;
    logic [31:0] now_ticks;
    logic [7:0]  sat_number;
    logic [6:0]  elevation;
    logic [8:0]  azimuth;
    logic [6:0]  snr;
  } item_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [3:0] slot;
    logic [7:0] out_number;
    logic [6:0] out_elevation;
    logic [8:0] out_azimuth;
    logic [6:0] out_snr;
    logic       last;
  } result_t;

  typedef struct packed {
    logic [6:0] snr;
    logic [8:0] azimuth;
    logic [6:0] elevation;
    logic [7:0] number;
  } payload_t;

  typedef struct packed {
    logic load;
    logic read;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic read_last;
  } ctrl_status_t;

endpackage

/* sv/satellite_table_with_aging_recycle.sv */
// Satellite table with aging and recycling, top level.
// Joins the controller and the datapath. Depends on stawr_pkg, stawr_ctrl and stawr_dpath.
//
// Usage: a command beat (item) is taken when start is high and busy is low.
// Mode store writes the report to the matching slot, else the lowest free slot,
// else the first slot old enough to recycle, else the slot with the oldest stamp,
// and returns one result beat with last set. Mode list returns one beat per
// valid slot younger than recent_ticks, in slot order, the final one with last
// set, or a single empty marker beat when none qualifies.
// Each item holds busy while the scan reads every slot through the registered
// read port of the slot memories and then through drain and close; a new item
// is taken only once busy has fallen. List entries appear during the scan; the
// final beat is on result in the first cycle in which busy is low again.
// Result beats are shown on result for one cycle with result_valid high; the
// receiver cannot stall, so no beat waits.
// Configuration writes (cfg_valid, always ready) are to be made only while the
// block is idle, a rule for the user that the block itself leaves unchecked.
// Synchronous reset empties the table and sets both limits to 10000 ticks.
module satellite_table_with_aging_recycle #(
  parameter int SLOTS     = stawr_pkg::SLOTS_DEFAULT,
  parameter int TIME_BITS = stawr_pkg::TIME_BITS_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  stawr_pkg::item_t                     item,
  output logic                                 result_valid,
  output stawr_pkg::result_t                   result,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [stawr_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [stawr_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

  stawr_pkg::ctrl_cmd_t    cmd;
  stawr_pkg::ctrl_status_t status;

  assign cfg_ready = 1'b1;

  stawr_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .status (status)
  );

  stawr_dpath #(
    .SLOTS     (SLOTS),
    .TIME_BITS (TIME_BITS)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .item         (item),
    .cmd          (cmd),
    .status       (status),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule

/* sv/stawr_ctrl.sv */
// Sequencing controller for the satellite table: accepts a command, steps the
// slot scan and closes the item. Depends on stawr_pkg.
module stawr_ctrl (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  output stawr_pkg::ctrl_cmd_t    cmd,
  input  stawr_pkg::ctrl_status_t status
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_READ   = 2'd1;
  localparam logic [1:0] ST_DRAIN  = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        cmd.read = 1'b1;
        if (status.read_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        cmd.finish = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != ST_IDLE);

endmodule

/* sv/stawr_dpath.sv */
// Datapath for the satellite table: configuration registers, slot memories,
// scan accumulators and the result register. Depends on stawr_pkg and the defines header.
`include "satellite_table_with_aging_recycle_defines.svh"

module stawr_dpath #(
  parameter int SLOTS     = stawr_pkg::SLOTS_DEFAULT,
  parameter int TIME_BITS = stawr_pkg::TIME_BITS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  input  logic [stawr_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [stawr_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  stawr_pkg::item_t                    item,
  input  stawr_pkg::ctrl_cmd_t                cmd,
  output stawr_pkg::ctrl_status_t             status,
  output logic                                result_valid,
  output stawr_pkg::result_t                  result
);

  localparam int IDX_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CMP_BITS = (TIME_BITS > 32) ? TIME_BITS : 32;

  logic [31:0] recycle_ticks;
  logic [31:0] recent_ticks;

  stawr_pkg::item_t item_q;
  logic [TIME_BITS-1:0] now_t;

  logic [SLOTS-1:0] valid;
  logic [TIME_BITS-1:0] stamp_mem [SLOTS];
  stawr_pkg::payload_t  pay_mem   [SLOTS];

  logic [IDX_W-1:0]     cnt;
  logic                 rd_ok;
  logic [IDX_W-1:0]     rd_idx;
  logic [TIME_BITS-1:0] stamp_q;
  stawr_pkg::payload_t  pay_q;
  logic                 val_q;

  logic                 m_found;
  logic [IDX_W-1:0]     m_idx;
  logic                 f_found;
  logic [IDX_W-1:0]     f_idx;
  logic                 r_found;
  logic [IDX_W-1:0]     r_idx;
  logic [TIME_BITS-1:0] best;
  logic [IDX_W-1:0]     b_idx;

  logic                 pend_ok;
  logic [IDX_W-1:0]     pend_idx;
  stawr_pkg::payload_t  pend_pay;

  logic [TIME_BITS-1:0] age;
  logic                 is_list;
  logic                 listed;
  logic                 aged_out;
  logic [IDX_W-1:0]     tgt_idx;
  logic [2:0]           tgt_kind;
  stawr_pkg::payload_t  new_pay;
  logic                 res_fire;
  stawr_pkg::result_t   res_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      recycle_ticks <= stawr_pkg::RECYCLE_RESET;
      recent_ticks  <= stawr_pkg::RECENT_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        stawr_pkg::REG_RECYCLE: recycle_ticks <= cfg_data;
        stawr_pkg::REG_RECENT:  recent_ticks  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign now_t    = TIME_BITS'(item_q.now_ticks);
  assign is_list  = (item_q.mode == stawr_pkg::MODE_LIST);
  assign age      = now_t - stamp_q;
  assign aged_out = (CMP_BITS'(age) >= CMP_BITS'(recycle_ticks));
  assign listed   = val_q && (CMP_BITS'(age) < CMP_BITS'(recent_ticks));
  assign status.read_last = (cnt == IDX_W'(SLOTS - 1));

  assign new_pay.number    = item_q.sat_number;
  assign new_pay.elevation = item_q.elevation;
  assign new_pay.azimuth   = item_q.azimuth;
  assign new_pay.snr       = item_q.snr;

  always_comb begin
    if (m_found) begin
      tgt_idx  = m_idx;
      tgt_kind = stawr_pkg::KIND_MATCH;
    end else if (f_found) begin
      tgt_idx  = f_idx;
      tgt_kind = stawr_pkg::KIND_FREE;
    end else if (r_found) begin
      tgt_idx  = r_idx;
      tgt_kind = stawr_pkg::KIND_RECYCLE;
    end else begin
      tgt_idx  = b_idx;
      tgt_kind = stawr_pkg::KIND_RECYCLE;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_q <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt   <= '0;
      rd_ok <= 1'b0;
    end else begin
      rd_ok <= cmd.read;
      if (cmd.load) begin
        cnt <= '0;
      end else if (cmd.read) begin
        cnt <= cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.read) begin
      stamp_q <= stamp_mem[cnt];
      pay_q   <= pay_mem[cnt];
      val_q   <= valid[cnt];
      rd_idx  <= cnt;
    end
    if (cmd.finish && !is_list) begin
      stamp_mem[tgt_idx] <= now_t;
      pay_mem[tgt_idx]   <= new_pay;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (cmd.finish && !is_list) begin
      valid[tgt_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      m_found <= 1'b0;
      m_idx   <= '0;
      f_found <= 1'b0;
      f_idx   <= '0;
      r_found <= 1'b0;
      r_idx   <= '0;
      best    <= '1;
      b_idx   <= '0;
      pend_ok <= 1'b0;
    end else if (rd_ok) begin
      if (is_list) begin
        if (listed) begin
          pend_ok  <= 1'b1;
          pend_idx <= rd_idx;
          pend_pay <= pay_q;
        end
      end else begin
        if (val_q && (pay_q.number == item_q.sat_number) && !m_found) begin
          m_found <= 1'b1;
          m_idx   <= rd_idx;
        end
        if (!val_q && !f_found) begin
          f_found <= 1'b1;
          f_idx   <= rd_idx;
        end
        if (!r_found) begin
          if (aged_out) begin
            r_found <= 1'b1;
            r_idx   <= rd_idx;
          end else if (stamp_q < best) begin
            best  <= stamp_q;
            b_idx <= rd_idx;
          end
        end
      end
    end
  end

  always_comb begin
    res_fire = 1'b0;
    res_next = '0;
    if (cmd.finish) begin
      res_fire      = 1'b1;
      res_next.last = 1'b1;
      if (!is_list) begin
        res_next.kind          = tgt_kind;
        res_next.slot          = 4'(tgt_idx);
        res_next.out_number    = new_pay.number;
        res_next.out_elevation = new_pay.elevation;
        res_next.out_azimuth   = new_pay.azimuth;
        res_next.out_snr       = new_pay.snr;
      end else if (pend_ok) begin
        res_next.kind          = stawr_pkg::KIND_LIST;
        res_next.slot          = 4'(pend_idx);
        res_next.out_number    = pend_pay.number;
        res_next.out_elevation = pend_pay.elevation;
        res_next.out_azimuth   = pend_pay.azimuth;
        res_next.out_snr       = pend_pay.snr;
      end else begin
        res_next.kind = stawr_pkg::KIND_EMPTY;
      end
    end else if (rd_ok && is_list && listed && pend_ok) begin
      res_fire               = 1'b1;
      res_next.kind          = stawr_pkg::KIND_LIST;
      res_next.slot          = 4'(pend_idx);
      res_next.out_number    = pend_pay.number;
      res_next.out_elevation = pend_pay.elevation;
      res_next.out_azimuth   = pend_pay.azimuth;
      res_next.out_snr       = pend_pay.snr;
      res_next.last          = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= res_fire;
    end
    if (res_fire) begin
      result <= res_next;
    end
  end

  `STAWR_ASSERT_NEXT(a_finish_closes, cmd.finish, result_valid && result.last, "item closed without a final beat")
  `STAWR_ASSERT_IMPL(a_only_list_open, result_valid && !result.last, result.kind == stawr_pkg::KIND_LIST, "non-final beat that is not a list entry")
  `STAWR_ASSERT_IMPL(a_read_follows, rd_ok, $past(cmd.read), "slot evaluated without a read")

endmodule
